// ===== rtl/pei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_pkg
// Shared types, constants and helpers of the particle euler integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STEP_BITS = 16;
    localparam int DIVW      = 2 * FRAC_BITS + 1;
    localparam int DIVCW     = $clog2(DIVW);
    localparam int OPW       = 33;
    localparam int PW        = 2 * OPW;
    localparam int IN_W      = 216;
    localparam int OUT_W     = 192;

    typedef enum logic [1:0] {
        FN_FORCE = 2'd0,
        FN_INTEG = 2'd1,
        FN_LOAD  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_MASS    = 3'd0,
        REG_DAMPING = 3'd1,
        REG_ACCEL_X = 3'd2,
        REG_ACCEL_Y = 3'd3,
        REG_ACCEL_Z = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        ST_HALF,
        ST_FA,
        ST_PV,
        ST_PA,
        ST_VD,
        ST_VA
    } t_step;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       div_first;
        logic       div_step;
        logic       mul_issue;
        t_step      step;
        logic [1:0] axis;
        logic       capture;
    } t_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [31:0] r;
        if (v[PW-1:31] == '0 || v[PW-1:31] == '1) begin
            r = v[31:0];
        end else if (v[PW-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

// ===== rtl/pei_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_datapath
// State, configuration, shared multiplier, restoring divider and output
// register of the integrator.
// ----------------------------------------------------------------------------
module pei_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pei_pkg::t_cmd               i_cmd,
    input  logic [1:0]                  i_func,
    input  logic [pei_pkg::IN_W-1:0]    i_data,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic [pei_pkg::OUT_W-1:0]   o_data
);
    import pei_pkg::*;

    logic        [31:0] r_mass;
    logic        [16:0] r_damping;
    logic signed [31:0] r_accel [3];
    logic signed [31:0] r_pos   [3];
    logic signed [31:0] r_vel   [3];
    logic signed [31:0] r_force [3];

    logic        [16:0]     r_dt;
    logic        [16:0]     r_half;
    logic        [31:0]     r_rem;
    logic        [DIVW-1:0] r_quo;
    logic signed [PW-1:0]   r_prod;
    logic                   r_post;
    t_step                  r_post_step;
    logic        [1:0]      r_post_axis;
    logic signed [31:0]     r_aeff;
    logic signed [PW-1:0]   r_pacc;
    logic signed [PW-1:0]   r_vacc;
    logic        [OUT_W-1:0] r_out;

    logic signed [31:0]  vec  [3];
    logic signed [31:0]  lvel [3];
    logic        [16:0]  in_dt;
    logic signed [31:0]  im;
    logic signed [OPW-1:0] op_a;
    logic signed [OPW-1:0] op_b;
    logic        [32:0]  rem_sh;
    logic                qbit;
    logic signed [PW-1:0] prod_frac;
    logic signed [PW-1:0] prod_step;
    logic signed [31:0]  fa;

    assign vec[0]  = i_data[31:0];
    assign vec[1]  = i_data[63:32];
    assign vec[2]  = i_data[95:64];
    assign lvel[0] = i_data[127:96];
    assign lvel[1] = i_data[159:128];
    assign lvel[2] = i_data[191:160];
    assign in_dt   = i_data[208:192];

    // inverse mass from the divider quotient, saturated; -1.0 when the mass is zero
    always_comb begin
        if (r_mass == '0) begin
            im = -(32'sd1 <<< FRAC_BITS);
        end else if (|r_quo[DIVW-1:31]) begin
            im = 32'sh7fff_ffff;
        end else begin
            im = r_quo[31:0];
        end
    end

    always_comb begin
        rem_sh = i_cmd.div_first ? 33'd1 : {r_rem, 1'b0};
        qbit   = (rem_sh >= {1'b0, r_mass});
    end

    always_comb begin
        unique case (i_cmd.step)
            ST_HALF: begin
                op_a = {16'b0, r_dt};
                op_b = {16'b0, r_dt};
            end
            ST_FA: begin
                op_a = OPW'(r_force[i_cmd.axis]);
                op_b = OPW'(im);
            end
            ST_PV: begin
                op_a = OPW'(r_vel[i_cmd.axis]);
                op_b = {16'b0, r_dt};
            end
            ST_PA: begin
                op_a = OPW'(r_accel[i_cmd.axis]);
                op_b = {16'b0, r_half};
            end
            ST_VD: begin
                op_a = OPW'(r_vel[i_cmd.axis]);
                op_b = {16'b0, r_damping};
            end
            ST_VA: begin
                op_a = OPW'(r_aeff);
                op_b = {16'b0, r_dt};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_frac = r_prod >>> FRAC_BITS;
    assign prod_step = r_prod >>> STEP_BITS;
    assign fa        = sat32(prod_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass    <= 32'(1) << FRAC_BITS;
            r_damping <= 17'd65536;
            r_post    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_accel[i] <= '0;
                r_pos[i]   <= '0;
                r_vel[i]   <= '0;
                r_force[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MASS:    r_mass     <= i_cfg_data;
                    REG_DAMPING: r_damping  <= i_cfg_data[16:0];
                    REG_ACCEL_X: r_accel[0] <= i_cfg_data;
                    REG_ACCEL_Y: r_accel[1] <= i_cfg_data;
                    REG_ACCEL_Z: r_accel[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (t_func'(i_func))
                    FN_FORCE: begin
                        for (int i = 0; i < 3; i++) begin
                            r_force[i] <= sat32(PW'(r_force[i]) + PW'(vec[i]));
                        end
                    end
                    FN_LOAD: begin
                        for (int i = 0; i < 3; i++) begin
                            r_pos[i] <= vec[i];
                            r_vel[i] <= lvel[i];
                        end
                    end
                    default: ;
                endcase
            end
            r_post <= i_cmd.mul_issue;
            if (r_post) begin
                unique case (r_post_step)
                    ST_PA: r_pos[r_post_axis] <= sat32(r_pacc + prod_step);
                    ST_VA: begin
                        r_vel[r_post_axis]   <= sat32(r_vacc + prod_step);
                        r_force[r_post_axis] <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dt <= in_dt;
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? 32'(rem_sh - {1'b0, r_mass}) : rem_sh[31:0];
            r_quo <= {r_quo[DIVW-2:0], qbit};
        end
        if (i_cmd.mul_issue) begin
            r_prod      <= op_a * op_b;
            r_post_step <= i_cmd.step;
            r_post_axis <= i_cmd.axis;
        end
        if (r_post) begin
            unique case (r_post_step)
                ST_HALF: r_half <= r_prod[STEP_BITS+1 +: 17];
                ST_FA:   r_aeff <= sat32(PW'(r_accel[r_post_axis]) + PW'(fa));
                ST_PV:   r_pacc <= PW'(r_pos[r_post_axis]) + prod_step;
                ST_VD:   r_vacc <= prod_step;
                default: ;
            endcase
        end
        if (i_cmd.capture) begin
            r_out <= {r_vel[2], r_vel[1], r_vel[0], r_pos[2], r_pos[1], r_pos[0]};
        end
    end

    assign o_data = r_out;

endmodule

// ===== rtl/pei_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pei_controller
// Sequencer: integrate = divide, dt*dt/2, five multiplies per axis; capture.
// ----------------------------------------------------------------------------
module pei_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic [1:0]    i_func,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output pei_pkg::t_cmd o_cmd
);
    import pei_pkg::*;

    t_state                r_state, n_state;
    logic [DIVCW-1:0]      r_div_cnt, n_div_cnt;
    t_step                 r_step, n_step;
    logic [1:0]            r_axis, n_axis;
    logic                  r_out_valid, n_out_valid;
    logic                  accept;

    assign accept = (r_state == S_IDLE) && i_s_tvalid;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_step    = r_step;
        n_axis    = r_axis;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_div_cnt = '0;
                    n_step    = ST_HALF;
                    n_axis    = 2'd0;
                    n_state   = (t_func'(i_func) == FN_INTEG) ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == DIVCW'(DIVW - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                unique case (r_step)
                    ST_HALF: n_step = ST_FA;
                    ST_FA:   n_step = ST_PV;
                    ST_PV:   n_step = ST_PA;
                    ST_PA:   n_step = ST_VD;
                    ST_VD:   n_step = ST_VA;
                    ST_VA: begin
                        n_step = ST_FA;
                        if (r_axis == 2'd2) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_axis = r_axis + 1'b1;
                        end
                    end
                    default: n_step = ST_HALF;
                endcase
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.step      = r_step;
        o_cmd.axis      = r_axis;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_first = (r_state == S_DIV) && (r_div_cnt == '0);
        o_cmd.mul_issue = (r_state == S_MUL);
        o_cmd.capture   = (r_state == S_DONE) && (!r_out_valid || i_m_tready);
        n_out_valid     = o_cmd.capture ? 1'b1 : (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_step      <= ST_HALF;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_no_issue_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.accept && (o_cmd.mul_issue || o_cmd.div_step)))
        else $error("accept during a busy step");
    a_integ_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_func'(i_func) == FN_INTEG) |=> o_cmd.div_first)
        else $error("integrate did not start the divider");
    a_capture_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (!r_out_valid || i_m_tready))
        else $error("capture over an untaken result");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule

// ===== rtl/particle_euler_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_integrator
// Damped euler integrator of one particle in signed fixed point.
// ----------------------------------------------------------------------------
// channel   direction  transaction
// s         in         one command item (func, vectors, dt)
// m         out        position and velocity after the item
// cfg       in         one register write (index, data)
//
// add force, load and unused func go from accept straight to the capture state.
// integrate runs the restoring divider for the inverse mass (2*FRAC_BITS+1
// quotient bits), one multiply for dt*dt/2 and five per axis on the shared
// multiplier, a drain state and the capture state.
// one item at a time; the result waits in an output register, so the next
// item is accepted while it is not yet taken; a full register stalls finish.
// reset is synchronous, active low; cfg writes are taken in every cycle.
// ----------------------------------------------------------------------------
module particle_euler_integrator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // vec_x, vec_y, vec_z, load_vx, load_vy, load_vz, dt, zero pad
    input  logic [pei_pkg::IN_W-1:0]  s_tdata,
    // func
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [pei_pkg::OUT_W-1:0] m_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import pei_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pei_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_func     (s_tuser),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (cmd)
    );

    pei_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (s_tuser),
        .i_data      (s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (m_tdata)
    );

endmodule
